// ===== src/qshq_pkg.sv =====
`default_nettype none
package qshq_pkg;

  localparam int NUM_REGS = 7;
  localparam int CFG_IDX_W = 3;
  localparam int REG_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL1 = 3'd6;

  // triangle codes
  localparam logic [1:0] TRI_MISS   = 2'd0;
  localparam logic [1:0] TRI_FIRST  = 2'd1;
  localparam logic [1:0] TRI_SECOND = 2'd2;

  // datapath widths
  localparam int DW   = 18;  // query offsets
  localparam int EW   = 17;  // edge vectors and base height
  localparam int FW   = 38;  // partial and full areas
  localparam int NUMW = 36;  // signed height numerator
  localparam int NW   = 36;  // rounded-division numerator, one quotient bit per stage
  localparam int DENW = 17;  // doubled |ny|
  localparam int QSAT = 18;  // quotient clamp exponent, beyond it height saturates anyway

  typedef struct packed {
    logic signed [15:0] query_z;
    logic signed [15:0] query_y;
    logic signed [15:0] query_x;
  } query_t;

  typedef struct packed {
    logic signed [15:0] hit_normal_z;
    logic signed [15:0] hit_normal_y;
    logic signed [15:0] hit_normal_x;
    logic [1:0]         hit_triangle;
    logic signed [15:0] surface_height;
  } result_t;

endpackage
`default_nettype wire

// ===== src/quad_surface_height_query_core.sv =====
`default_nettype none
// Quad surface height query.
// Input channel (in_valid/in_ready/in_data) takes one query point per beat,
// Q12.4 x,y,z. Result channel (out_valid/out_ready/out_data) returns one beat
// per query, in order: plane height (Q12.4, saturated), hit triangle code and
// the hit triangle's normal. Misses return the query y and a zero normal.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the seven
// quad registers; cfg_ready is always high, unknown indexes are dropped.
// Write config only while no query is in flight.
// Throughput: one query per cycle while the output is not stalled. Pipeline:
// three geometry stages (offsets, area products, hit test and operand setup),
// 36 stages of the restoring divider (one quotient bit each) and the output
// register.
// Reset (synchronous, rst_n low) clears the config registers and pipeline valids.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; bubbles in the pipe still move up while the output is empty.
module quad_surface_height_query_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  qshq_pkg::query_t                  in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output qshq_pkg::result_t                 out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [qshq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [qshq_pkg::REG_W-1:0]        cfg_data
);

  localparam int DW   = qshq_pkg::DW;
  localparam int EW   = qshq_pkg::EW;
  localparam int FW   = qshq_pkg::FW;
  localparam int NUMW = qshq_pkg::NUMW;
  localparam int NW   = qshq_pkg::NW;
  localparam int DENW = qshq_pkg::DENW;
  localparam int QSAT = qshq_pkg::QSAT;

  // stage context carried alongside the divider
  typedef struct packed {
    logic [1:0]              tri_code;
    logic                    neg;
    logic signed [EW-1:0]    base;
    logic signed [15:0]      qy;
    logic [47:0]             normal;
    logic [DENW-1:0]         den;
  } ctx_t;

  // ---------------- config registers
  logic [qshq_pkg::REG_W-1:0] regs_r [qshq_pkg::NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qshq_pkg::NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qshq_pkg::REG_ORIGIN:  regs_r[0] <= cfg_data;
        qshq_pkg::REG_CORNER0: regs_r[1] <= cfg_data;
        qshq_pkg::REG_CORNER1: regs_r[2] <= cfg_data;
        qshq_pkg::REG_CORNER2: regs_r[3] <= cfg_data;
        qshq_pkg::REG_CORNER3: regs_r[4] <= cfg_data;
        qshq_pkg::REG_NORMAL0: regs_r[5] <= cfg_data;
        qshq_pkg::REG_NORMAL1: regs_r[6] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] ox, oy, oz, c0x, c0y, c0z, c1x, c1z, c2x, c2z, c3x, c3y, c3z;
  logic signed [15:0] n0x, n0y, n0z, n1x, n1y, n1z;
  assign ox  = regs_r[0][15:0];  assign oy  = regs_r[0][31:16]; assign oz  = regs_r[0][47:32];
  assign c0x = regs_r[1][15:0];  assign c0y = regs_r[1][31:16]; assign c0z = regs_r[1][47:32];
  assign c1x = regs_r[2][15:0];  assign c1z = regs_r[2][47:32];
  assign c2x = regs_r[3][15:0];  assign c2z = regs_r[3][47:32];
  assign c3x = regs_r[4][15:0];  assign c3y = regs_r[4][31:16]; assign c3z = regs_r[4][47:32];
  assign n0x = regs_r[5][15:0];  assign n0y = regs_r[5][31:16]; assign n0z = regs_r[5][47:32];
  assign n1x = regs_r[6][15:0];  assign n1y = regs_r[6][31:16]; assign n1z = regs_r[6][47:32];

  // edges of both triangles (static while queries run)
  logic signed [EW-1:0] e1x0, e1z0, e2x0, e2z0, e1x1, e1z1, e2x1, e2z1;
  assign e1x0 = EW'(c1x) - EW'(c0x);
  assign e1z0 = EW'(c1z) - EW'(c0z);
  assign e2x0 = EW'(c2x) - EW'(c0x);
  assign e2z0 = EW'(c2z) - EW'(c0z);
  assign e1x1 = EW'(c1x) - EW'(c3x);
  assign e1z1 = EW'(c1z) - EW'(c3z);
  assign e2x1 = EW'(c2x) - EW'(c3x);
  assign e2z1 = EW'(c2z) - EW'(c3z);

  // global advance: hold everything while a result waits unread
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: offsets from the anchors
  logic                 v1_r;
  logic signed [DW-1:0] dx0_r, dz0_r, dx1_r, dz1_r;
  logic signed [15:0]   qy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx0_r <= DW'(in_data.query_x) - (DW'(ox) + DW'(c0x));
      dz0_r <= DW'(in_data.query_z) - (DW'(oz) + DW'(c0z));
      dx1_r <= DW'(in_data.query_x) - (DW'(ox) + DW'(c3x));
      dz1_r <= DW'(in_data.query_z) - (DW'(oz) + DW'(c3z));
      qy1_r <= in_data.query_y;
    end
  end

  // ---------------- stage 2: partial areas and height numerators
  logic                   v2_r;
  logic signed [FW-1:0]   f0_r, g0_r, a0_r, f1_r, g1_r, a1_r;
  logic signed [NUMW-1:0] num0_r, num1_r;
  logic signed [15:0]     qy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_r   <= FW'(dx0_r * e2z0) - FW'(dz0_r * e2x0);
      g0_r   <= FW'(dz0_r * e1x0) - FW'(dx0_r * e1z0);
      a0_r   <= FW'(e1x0 * e2z0) - FW'(e1z0 * e2x0);
      f1_r   <= FW'(dx1_r * e2z1) - FW'(dz1_r * e2x1);
      g1_r   <= FW'(dz1_r * e1x1) - FW'(dx1_r * e1z1);
      a1_r   <= FW'(e1x1 * e2z1) - FW'(e1z1 * e2x1);
      num0_r <= NUMW'(dx0_r * n0x) + NUMW'(dz0_r * n0z);
      num1_r <= NUMW'(dx1_r * n1x) + NUMW'(dz1_r * n1z);
      qy2_r  <= qy1_r;
    end
  end

  // ---------------- stage 3: hit test, triangle select, divider operands
  logic hit0, hit1;
  logic signed [FW-1:0] fg0, fg1;
  assign fg0 = f0_r + g0_r;
  assign fg1 = f1_r + g1_r;

  always_comb begin
    if (a0_r > 0)
      hit0 = f0_r >= 0 && f0_r <= a0_r && g0_r >= 0 && g0_r <= a0_r && fg0 <= a0_r;
    else
      hit0 = f0_r <= 0 && f0_r >= a0_r && g0_r <= 0 && g0_r >= a0_r && fg0 >= a0_r;
    hit0 = hit0 && (n0y != 0) && (a0_r != 0);
    if (a1_r > 0)
      hit1 = f1_r >= 0 && f1_r <= a1_r && g1_r >= 0 && g1_r <= a1_r && fg1 <= a1_r;
    else
      hit1 = f1_r <= 0 && f1_r >= a1_r && g1_r <= 0 && g1_r >= a1_r && fg1 >= a1_r;
    hit1 = hit1 && (n1y != 0) && (a1_r != 0);
  end

  logic signed [NUMW-1:0] sel_num;
  logic signed [15:0]     sel_ny;
  logic [NUMW-1:0]        abs_num;
  logic [DENW-2:0]        abs_ny;
  ctx_t                   ctx3;

  always_comb begin
    ctx3.qy = qy2_r;
    if (hit0) begin
      ctx3.tri_code = qshq_pkg::TRI_FIRST;
      ctx3.normal   = regs_r[5];
      ctx3.base     = EW'(oy) + EW'(c0y);
      sel_num       = num0_r;
      sel_ny        = n0y;
    end else if (hit1) begin
      ctx3.tri_code = qshq_pkg::TRI_SECOND;
      ctx3.normal   = regs_r[6];
      ctx3.base     = EW'(oy) + EW'(c3y);
      sel_num       = num1_r;
      sel_ny        = n1y;
    end else begin
      ctx3.tri_code = qshq_pkg::TRI_MISS;
      ctx3.normal   = '0;
      ctx3.base     = '0;
      sel_num       = '0;
      sel_ny        = 16'sd1;
    end
    abs_num  = sel_num[NUMW-1] ? NUMW'(-sel_num) : NUMW'(sel_num);
    abs_ny   = sel_ny[15] ? (DENW-1)'(-(DENW'(sel_ny))) : (DENW-1)'(sel_ny);
    ctx3.neg = sel_num[NUMW-1] != sel_ny[15];
    ctx3.den = {abs_ny, 1'b0};
  end

  // divider pipeline: stage k holds remainder and shifted numerator/quotient
  logic                v_d_r   [NW+1];
  logic [DENW-1:0]     rem_d_r [NW+1];
  logic [NW-1:0]       rq_d_r  [NW+1];
  ctx_t                ctx_d_r [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_d_r[0] <= 1'b0;
    else if (adv) v_d_r[0] <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_d_r[0] <= '0;
      rq_d_r[0]  <= NW'({abs_num, 1'b0}) + NW'(abs_ny);
      ctx_d_r[0] <= ctx3;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DENW:0] trial;
    logic          geq;
    assign trial = {rem_d_r[k], rq_d_r[k][NW-1]};
    assign geq   = trial >= {1'b0, ctx_d_r[k].den};

    always_ff @(posedge clk) begin
      if (!rst_n) v_d_r[k+1] <= 1'b0;
      else if (adv) v_d_r[k+1] <= v_d_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_d_r[k+1] <= geq ? DENW'(trial - {1'b0, ctx_d_r[k].den}) : DENW'(trial);
        rq_d_r[k+1]  <= {rq_d_r[k][NW-2:0], geq};
        ctx_d_r[k+1] <= ctx_d_r[k];
      end
    end
  end

  // ---------------- final: sign, subtract, saturate
  ctx_t                  ctx_f;
  logic [QSAT:0]         q_clamp;
  logic signed [QSAT+2:0] q_s;
  logic signed [QSAT+2:0] h_full;
  logic signed [15:0]    h_sat;
  qshq_pkg::result_t     res_nxt;
  qshq_pkg::result_t     out_data_r;

  assign ctx_f = ctx_d_r[NW];

  always_comb begin
    if (|rq_d_r[NW][NW-1:QSAT]) q_clamp = (QSAT+1)'(1) << QSAT;
    else                        q_clamp = (QSAT+1)'(rq_d_r[NW][QSAT-1:0]);
    q_s    = ctx_f.neg ? -($signed({2'b00, q_clamp})) : $signed({2'b00, q_clamp});
    h_full = (QSAT+3)'(ctx_f.base) - q_s;
    if (h_full > 32767)       h_sat = 16'sh7fff;
    else if (h_full < -32768) h_sat = -16'sh8000;
    else                      h_sat = h_full[15:0];
    res_nxt.hit_triangle = ctx_f.tri_code;
    res_nxt.hit_normal_x = ctx_f.normal[15:0];
    res_nxt.hit_normal_y = ctx_f.normal[31:16];
    res_nxt.hit_normal_z = ctx_f.normal[47:32];
    res_nxt.surface_height = (ctx_f.tri_code == qshq_pkg::TRI_MISS) ? ctx_f.qy : h_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v_d_r[NW];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/tb_quad_surface_height_query_core.sv =====
`default_nettype none
module tb_quad_surface_height_query_core;

  localparam int LATENCY   = 40;
  localparam int STALL_MAX = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  qshq_pkg::query_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  qshq_pkg::result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [qshq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qshq_pkg::REG_W-1:0] cfg_data = '0;

  quad_surface_height_query_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the quad registers
  logic [qshq_pkg::REG_W-1:0] quad_regs [qshq_pkg::NUM_REGS];
  qshq_pkg::result_t pending_heights [$];
  int errors = 0;
  int n_queries = 0, n_results = 0;
  int n_hit [3] = '{0, 0, 0};
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;

  function automatic longint fld(logic [qshq_pkg::REG_W-1:0] r, int k);
    logic signed [15:0] v;
    v = r[16*k +: 16];
    return longint'(v);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint un, ud, q;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (2 * un + ud) / (2 * ud);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // returns 1 on hit, height through h
  function automatic bit tri_height(int anchor, int nreg, longint qx, longint qz,
                                    output longint h);
    logic [qshq_pkg::REG_W-1:0] org, pa, p1, p2, nr;
    longint nx, ny, nz, e1x, e1z, e2x, e2z, dx, dz, base, area, f, g;
    bit hit;
    org = quad_regs[qshq_pkg::REG_ORIGIN];
    pa  = quad_regs[qshq_pkg::REG_CORNER0 + anchor];
    p1  = quad_regs[qshq_pkg::REG_CORNER1];
    p2  = quad_regs[qshq_pkg::REG_CORNER2];
    nr  = quad_regs[nreg];
    nx = fld(nr, 0); ny = fld(nr, 1); nz = fld(nr, 2);
    e1x = fld(p1, 0) - fld(pa, 0);
    e1z = fld(p1, 2) - fld(pa, 2);
    e2x = fld(p2, 0) - fld(pa, 0);
    e2z = fld(p2, 2) - fld(pa, 2);
    dx = qx - (fld(org, 0) + fld(pa, 0));
    dz = qz - (fld(org, 2) + fld(pa, 2));
    base = fld(org, 1) + fld(pa, 1);
    area = e1x * e2z - e1z * e2x;
    f = dx * e2z - dz * e2x;
    g = dz * e1x - dx * e1z;
    h = 0;
    if (ny == 0 || area == 0) return 1'b0;
    if (area > 0) hit = f >= 0 && f <= area && g >= 0 && g <= area && f + g <= area;
    else          hit = f <= 0 && f >= area && g <= 0 && g >= area && f + g >= area;
    if (!hit) return 1'b0;
    h = base - round_div(dx * nx + dz * nz, ny);
    if (h > 32767) h = 32767;
    if (h < -32768) h = -32768;
    return 1'b1;
  endfunction

  function automatic qshq_pkg::result_t predict_height(qshq_pkg::query_t q);
    qshq_pkg::result_t r;
    longint h;
    logic [qshq_pkg::REG_W-1:0] nr;
    r = '0;
    nr = '0;
    if (tri_height(0, qshq_pkg::REG_NORMAL0, q.query_x, q.query_z, h)) begin
      r.hit_triangle = qshq_pkg::TRI_FIRST;
      nr = quad_regs[qshq_pkg::REG_NORMAL0];
    end else if (tri_height(3, qshq_pkg::REG_NORMAL1, q.query_x, q.query_z, h)) begin
      r.hit_triangle = qshq_pkg::TRI_SECOND;
      nr = quad_regs[qshq_pkg::REG_NORMAL1];
    end else begin
      r.hit_triangle = qshq_pkg::TRI_MISS;
      h = q.query_y;
    end
    r.surface_height = 16'(h);
    r.hit_normal_x = nr[15:0];
    r.hit_normal_y = nr[31:16];
    r.hit_normal_z = nr[47:32];
    return r;
  endfunction

  function automatic logic [qshq_pkg::REG_W-1:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // one write beat, then the config channel idles before the task returns
  task automatic write_reg(logic [qshq_pkg::CFG_IDX_W-1:0] idx,
                           logic [qshq_pkg::REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < qshq_pkg::NUM_REGS) quad_regs[idx] = val;
    @(posedge clk);
  endtask

  // send one query; expectation pushed on acceptance, valid left high
  task automatic send_query(qshq_pkg::query_t q, bit typed, qshq_pkg::result_t want);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (!in_ready);
    pending_heights.push_back(typed ? want : predict_height(q));
    n_queries++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else if (no_idle) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 4) != 0);
  end

  int long_hold = 0;
  initial begin
    wait (hold_off);
    long_hold = 0;
    while (long_hold < 120) begin
      @(posedge clk);
      long_hold++;
    end
    hold_off = 1'b0;
  end

  // checker
  always @(posedge clk) begin
    qshq_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_heights.size() == 0) begin
        $error("result beat with no query pending");
        errors++;
      end else begin
        want = pending_heights.pop_front();
        if (out_data.hit_triangle < 3) n_hit[out_data.hit_triangle]++;
        if (out_data.surface_height !== want.surface_height) begin
          $error("surface_height exp %0d got %0d", want.surface_height,
                 out_data.surface_height); errors++; end
        if (out_data.hit_triangle !== want.hit_triangle) begin
          $error("hit_triangle exp %0d got %0d", want.hit_triangle,
                 out_data.hit_triangle); errors++; end
        if (out_data.hit_normal_x !== want.hit_normal_x) begin
          $error("hit_normal_x exp %0d got %0d", want.hit_normal_x,
                 out_data.hit_normal_x); errors++; end
        if (out_data.hit_normal_y !== want.hit_normal_y) begin
          $error("hit_normal_y exp %0d got %0d", want.hit_normal_y,
                 out_data.hit_normal_y); errors++; end
        if (out_data.hit_normal_z !== want.hit_normal_z) begin
          $error("hit_normal_z exp %0d got %0d", want.hit_normal_z,
                 out_data.hit_normal_z); errors++; end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > STALL_MAX + LATENCY * 4) begin
      $display("timeout");
      $display("** quad_surface_height_query_core: FAILED **");
      $finish;
    end
  end

  // directed rows: query, whether result typed in, expected result
  typedef struct {
    qshq_pkg::query_t q;
    bit typed;
    qshq_pkg::result_t want;
  } vec_row_t;

  function automatic vec_row_t row(int x, int y, int z, bit typed, qshq_pkg::result_t w);
    vec_row_t r;
    r.q = '{query_z: 16'(z), query_y: 16'(y), query_x: 16'(x)};
    r.typed = typed;
    r.want = w;
    return r;
  endfunction

  function automatic qshq_pkg::result_t miss_of(int y);
    qshq_pkg::result_t r;
    r = '0;
    r.surface_height = 16'(y);
    r.hit_triangle = qshq_pkg::TRI_MISS;
    return r;
  endfunction

  // random corner in a modest box, or a wide one now and then
  function automatic int rcoord(bit wide);
    return wide ? int'($urandom_range(0, 65535)) - 32768 : int'($urandom_range(0, 800)) - 400;
  endfunction

  function automatic int rnormal();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16384;
      2: return -16384;
      3: return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  task automatic random_quad(bit wide);
    write_reg(qshq_pkg::REG_ORIGIN,  pack3(rcoord(wide), rcoord(wide), rcoord(wide)));
    write_reg(qshq_pkg::REG_CORNER0, pack3(rcoord(wide), rcoord(wide), rcoord(wide)));
    write_reg(qshq_pkg::REG_CORNER1, pack3(rcoord(wide), rcoord(wide), rcoord(wide)));
    write_reg(qshq_pkg::REG_CORNER2, pack3(rcoord(wide), rcoord(wide), rcoord(wide)));
    write_reg(qshq_pkg::REG_CORNER3, pack3(rcoord(wide), rcoord(wide), rcoord(wide)));
    write_reg(qshq_pkg::REG_NORMAL0, pack3(rnormal(), rnormal() | 1, rnormal()));
    write_reg(qshq_pkg::REG_NORMAL1, pack3(rnormal(), rnormal(), rnormal()));
  endtask

  // query near the quad most of the time, so the hit paths get exercised
  function automatic qshq_pkg::query_t random_query();
    qshq_pkg::query_t q;
    int ox, oz;
    logic [qshq_pkg::REG_W-1:0] c;
    q.query_x = 16'($urandom);
    q.query_y = 16'($urandom);
    q.query_z = 16'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      c = quad_regs[qshq_pkg::REG_CORNER0 + 3 * $urandom_range(0, 1)];
      ox = int'(fld(quad_regs[qshq_pkg::REG_ORIGIN], 0) + fld(c, 0));
      oz = int'(fld(quad_regs[qshq_pkg::REG_ORIGIN], 2) + fld(c, 2));
      q.query_x = 16'(ox + int'($urandom_range(0, 800)) - 400);
      q.query_z = 16'(oz + int'($urandom_range(0, 800)) - 400);
    end
    return q;
  endfunction

  initial begin
    vec_row_t rows [$];
    qshq_pkg::result_t w;
    qshq_pkg::query_t q;
    for (int i = 0; i < qshq_pkg::NUM_REGS; i++) quad_regs[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: zero normals and area, every query misses
    rows.push_back(row(0, 0, 0, 1'b1, miss_of(0)));
    rows.push_back(row(32767, 32767, 32767, 1'b1, miss_of(32767)));
    rows.push_back(row(-32768, -32768, -32768, 1'b1, miss_of(-32768)));
    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].want);
    drain();

    // unit right triangles: (0,0),(16,0),(0,16) and (16,16)
    write_reg(qshq_pkg::REG_ORIGIN,  pack3(0, 32, 0));
    write_reg(qshq_pkg::REG_CORNER0, pack3(0, 0, 0));
    write_reg(qshq_pkg::REG_CORNER1, pack3(16, 0, 0));
    write_reg(qshq_pkg::REG_CORNER2, pack3(0, 0, 16));
    write_reg(qshq_pkg::REG_CORNER3, pack3(16, 0, 16));
    write_reg(qshq_pkg::REG_NORMAL0, pack3(0, 16384, 0));
    write_reg(qshq_pkg::REG_NORMAL1, pack3(0, -16384, 0));
    write_reg(3'd7, '1);  // unknown index, dropped
    rows.delete();
    w = '0; w.surface_height = 32; w.hit_triangle = qshq_pkg::TRI_FIRST;
    w.hit_normal_y = 16384;
    rows.push_back(row(0, 5, 0, 1'b1, w));     // on the anchor
    rows.push_back(row(4, 5, 4, 1'b1, w));
    w.hit_triangle = qshq_pkg::TRI_SECOND; w.hit_normal_y = -16384;
    rows.push_back(row(12, 5, 12, 1'b1, w));
    rows.push_back(row(16, 5, 16, 1'b1, w));   // far corner
    rows.push_back(row(-1, 7, 0, 1'b1, miss_of(7)));
    rows.push_back(row(17, -9, 17, 1'b1, miss_of(-9)));
    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].want);
    drain();

    // sloped planes and saturation, checked against the predictor
    write_reg(qshq_pkg::REG_ORIGIN,  pack3(-32768, 32767, 32767));
    write_reg(qshq_pkg::REG_CORNER0, pack3(0, 32767, -32768));
    write_reg(qshq_pkg::REG_CORNER1, pack3(32767, 0, -32768));
    write_reg(qshq_pkg::REG_CORNER2, pack3(0, 0, 32767));
    write_reg(qshq_pkg::REG_CORNER3, pack3(32767, -32768, 32767));
    write_reg(qshq_pkg::REG_NORMAL0, pack3(-32768, 1, 32767));
    write_reg(qshq_pkg::REG_NORMAL1, pack3(32767, -1, -32768));
    rows.delete();
    rows.push_back(row(-32768, 0, 0, 1'b0, w));
    rows.push_back(row(-16000, 0, -16000, 1'b0, w));
    rows.push_back(row(-100, 0, 100, 1'b0, w));
    rows.push_back(row(32767, 0, 32767, 1'b0, w));
    rows.push_back(row(0, 0, 0, 1'b0, w));
    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].want);
    drain();

    // zero area: all corners on one line in XZ, normal y nonzero
    write_reg(qshq_pkg::REG_CORNER0, pack3(0, 0, 0));
    write_reg(qshq_pkg::REG_CORNER1, pack3(16, 0, 16));
    write_reg(qshq_pkg::REG_CORNER2, pack3(32, 0, 32));
    write_reg(qshq_pkg::REG_NORMAL0, pack3(100, 16384, -100));
    send_query('{query_z: 16'sd16, query_y: 16'sd3, query_x: 16'sd16}, 1'b1, miss_of(3));
    drain();

    // random phases with fresh quads; one long output hold-off
    for (int ph = 0; ph < 12; ph++) begin
      random_quad(ph == 0 || ph == 7);
      if (ph == 3) hold_off = 1'b1;
      if (ph == 11) no_idle = 1'b1;
      for (int k = 0; k < 50; k++) begin
        q = random_query();
        send_query(q, 1'b0, w);
      end
      drain();
    end

    $display("queries %0d, results %0d: miss %0d, first %0d, second %0d",
             n_queries, n_results, n_hit[0], n_hit[1], n_hit[2]);
    $display("covered reset state, unit quad, extremes, zero area and random quads");
    if (errors == 0 && pending_heights.size() == 0)
      $display("** quad_surface_height_query_core: PASSED **");
    else
      $display("** quad_surface_height_query_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
src/qshq_pkg.sv
src/quad_surface_height_query_core.sv
tb/tb_quad_surface_height_query_core.sv
